// ===== design/modbus_meter_poll_receiver_core_assert.svh =====
// Assertion macros shared by the Modbus meter poll receiver RTL.
`ifndef MODBUS_METER_POLL_RECEIVER_CORE_ASSERT_SVH
`define MODBUS_METER_POLL_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MMPR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MMPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mmpr_pkg.sv =====
// Package with types, constants and CRC helpers of the Modbus meter poll receiver.
package mmpr_pkg;

  // Reply frame: address, function, byte count, 20 data bytes, CRC low, CRC high.
  localparam int RESPONSE_BYTES = 25;
  localparam int COUNT_W        = $clog2(RESPONSE_BYTES + 1);
  localparam int SHIFT_DEPTH    = RESPONSE_BYTES - 1;

  // Request frame.
  localparam int REQ_BYTES = 8;
  localparam int BEAT_W    = $clog2(REQ_BYTES);

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_TIMEOUT = 2'd2;

  localparam logic [7:0]  DEVICE_ADDRESS_RESET   = 8'd248;
  localparam logic [15:0] POLL_INTERVAL_RESET    = 16'd1000;
  localparam logic [15:0] RESPONSE_TIMEOUT_RESET = 16'd200;

  // Input item and result kinds.
  localparam logic FUNC_BYTE   = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FRAME   = 2'd1,
    STATUS_RANGE   = 2'd2,
    STATUS_TIMEOUT = 2'd3
  } status_t;

  // Modbus read-holding-registers request fields.
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  START_REG_HI      = 8'h00;
  localparam logic [7:0]  START_REG_LO      = 8'h00;
  localparam logic [7:0]  REG_COUNT_HI      = 8'h00;
  localparam logic [7:0]  REG_COUNT_LO      = 8'h0A;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] TICK_SAT          = 16'hFFFF;

  // Byte offsets of the decoded registers inside the reply frame.
  localparam int OFS_ADDR    = 0;
  localparam int OFS_FUNC    = 1;
  localparam int OFS_VOLTAGE = 3;
  localparam int OFS_CURRENT = 5;
  localparam int OFS_POWER   = 9;
  localparam int OFS_ENERGY  = 13;
  localparam int OFS_FREQ    = 17;
  localparam int OFS_PF      = 19;
  localparam int OFS_ALARM   = 21;
  localparam int OFS_CRC_LO  = RESPONSE_BYTES - 2;
  localparam int OFS_CRC_HI  = RESPONSE_BYTES - 1;

  // Plausibility bounds, inclusive, in raw register units.
  localparam logic [15:0] VOLT_MIN  = 16'd800;
  localparam logic [15:0] VOLT_MAX  = 16'd2700;
  localparam logic [31:0] CURR_MAX  = 32'd100000;
  localparam logic [31:0] POWER_MAX = 32'd300000;
  localparam logic [15:0] FREQ_MIN  = 16'd450;
  localparam logic [15:0] FREQ_MAX  = 16'd650;
  localparam logic [15:0] PF_MAX    = 16'd100;

  // One byte of Modbus CRC16, reflected, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC of a whole request; evaluated only on constants.
  function automatic logic [15:0] req_crc_full(input logic [7:0] addr);
    logic [15:0] c;
    c = crc_byte(CRC_INIT, addr);
    c = crc_byte(c, FUNC_READ_HOLDING);
    c = crc_byte(c, START_REG_HI);
    c = crc_byte(c, START_REG_LO);
    c = crc_byte(c, REG_COUNT_HI);
    c = crc_byte(c, REG_COUNT_LO);
    return c;
  endfunction

  // The request CRC is affine in the address byte: a base term plus one
  // column for each address bit.
  localparam logic [15:0] REQ_CRC_BASE = req_crc_full(8'h00);
  localparam logic [15:0] REQ_CRC_COL [8] = '{
    req_crc_full(8'h01) ^ REQ_CRC_BASE,
    req_crc_full(8'h02) ^ REQ_CRC_BASE,
    req_crc_full(8'h04) ^ REQ_CRC_BASE,
    req_crc_full(8'h08) ^ REQ_CRC_BASE,
    req_crc_full(8'h10) ^ REQ_CRC_BASE,
    req_crc_full(8'h20) ^ REQ_CRC_BASE,
    req_crc_full(8'h40) ^ REQ_CRC_BASE,
    req_crc_full(8'h80) ^ REQ_CRC_BASE
  };

endpackage

// ===== design/modbus_meter_poll_receiver_core.sv =====
// Top level of the Modbus RTU meter poll receiver: request, reply check, decode.
//   Input channel (in_valid / in_stall) carries one item per transfer: either
//   a one millisecond tick (func = 1) or a received UART byte (func = 0).
//   Output channel (out_valid / out_stall) carries result items: transmit
//   bytes of a read request (kind = 0) or measurement reports (kind = 1);
//   last marks the final result caused by one input item.
//   Configuration (cfg_write, cfg_index, cfg_data) writes device_address,
//   poll_interval and response_timeout; write only while the block is idle.
// Timing:
//   Each item is decoded in the cycle it is transferred and its first result
//   sits in the output register in the next cycle. A report is one result; a
//   request is eight results, one per cycle from the output register unless
//   out_stall holds them. Sustained rate is one item per cycle unless the
//   output stalls; a request tick holds the input until the last of its eight
//   output transfers. The input takes a new item in the same cycle the last
//   pending result transfers out, so a free-flowing output never idles it.
// Reset (rst, synchronous) clears the output register, the reply tracking,
// the tick counters, the error counter and the held energy and alarm, and
// loads the register defaults. When the receiver stalls, the result and the
// burst position hold and the input stalls as well.
`include "modbus_meter_poll_receiver_core_assert.svh"

module modbus_meter_poll_receiver_core (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [mmpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mmpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [7:0]                         rx_byte,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic [7:0]                         tx_byte,
  output logic                               last,
  output logic [1:0]                         status,
  output logic [15:0]                        voltage_dv,
  output logic [31:0]                        current_ma,
  output logic [31:0]                        power_dw,
  output logic [31:0]                        energy_wh,
  output logic [15:0]                        frequency_dhz,
  output logic [15:0]                        power_factor_pct,
  output logic [15:0]                        alarm_word,
  output logic [31:0]                        error_total
);

  localparam int RB = mmpr_pkg::RESPONSE_BYTES;
  localparam int CW = mmpr_pkg::COUNT_W;
  localparam int BW = mmpr_pkg::BEAT_W;

  // Configuration registers.
  logic [7:0]  device_address;
  logic [15:0] poll_interval;
  logic [15:0] response_timeout;

  // Poll and reply tracking state.
  logic          awaiting_reply;
  logic [15:0]   poll_ticks;
  logic [15:0]   wait_ticks;
  logic [CW-1:0] byte_count;
  logic [15:0]   running_crc;
  logic [31:0]   error_counter;
  logic [31:0]   held_energy;
  logic [15:0]   held_alarm;

  // Reply bytes, newest in entry 0; the final byte is taken straight from the input.
  logic [7:0] frame_shift [mmpr_pkg::SHIFT_DEPTH];

  // Request burst position in the output register.
  logic [BW-1:0] beat;

  // Handshake.
  logic in_fire;
  logic out_fire;
  logic is_byte;
  logic is_tick;

  // Byte path.
  logic          take_byte;
  logic          frame_done;
  logic [15:0]   crc_next;
  logic [CW-1:0] count_inc;
  logic [7:0]    frame_byte [RB];
  logic [15:0]   recv_crc;
  logic          header_ok;
  logic          range_ok;
  logic [15:0]   dec_voltage;
  logic [31:0]   dec_current;
  logic [31:0]   dec_power;
  logic [31:0]   dec_energy;
  logic [15:0]   dec_freq;
  logic [15:0]   dec_pf;
  logic [15:0]   dec_alarm;

  // Tick path.
  logic [15:0] poll_sat;
  logic [15:0] wait_sat;
  logic        timeout_hit;
  logic        start_req;

  // Report assembly.
  logic                  report_now;
  logic                  err_inc;
  logic [31:0]           error_next;
  logic [31:0]           held_energy_next;
  logic [15:0]           held_alarm_next;
  mmpr_pkg::status_t     status_next;
  logic                  pass_values;

  // Request bytes.
  logic [15:0]   req_crc;
  logic [7:0]    req_bytes [mmpr_pkg::REQ_BYTES];
  logic [BW-1:0] beat_inc;

  // ---------------------------------------------------------------------------
  // Handshake: hold the input while any result is pending, except when the
  // last pending result transfers out in this cycle.
  // ---------------------------------------------------------------------------
  assign out_fire = out_valid & ~out_stall;
  assign in_stall = out_valid & ~(out_fire & last);
  assign in_fire  = in_valid & ~in_stall;
  assign is_byte  = in_fire & (func == mmpr_pkg::FUNC_BYTE);
  assign is_tick  = in_fire & (func == mmpr_pkg::FUNC_TICK);

  // ---------------------------------------------------------------------------
  // Byte path: fold the byte into the CRC, check and decode on the final byte.
  // Bytes while idle are dropped.
  // ---------------------------------------------------------------------------
  assign take_byte  = is_byte & awaiting_reply;
  assign frame_done = take_byte & (byte_count == CW'(RB - 1));
  assign crc_next   = mmpr_pkg::crc_byte(running_crc, rx_byte);
  assign count_inc  = byte_count + CW'(1);

  always_comb begin
    for (int i = 0; i < RB - 1; i++) begin
      frame_byte[i] = frame_shift[RB - 2 - i];
    end
    frame_byte[RB - 1] = rx_byte;
  end

  assign recv_crc = {frame_byte[mmpr_pkg::OFS_CRC_HI], frame_byte[mmpr_pkg::OFS_CRC_LO]};

  assign header_ok = (frame_byte[mmpr_pkg::OFS_ADDR] == device_address) &&
                     (frame_byte[mmpr_pkg::OFS_FUNC] == mmpr_pkg::FUNC_READ_HOLDING) &&
                     (recv_crc == running_crc);

  // Meter registers are big-endian.
  assign dec_voltage = {frame_byte[mmpr_pkg::OFS_VOLTAGE], frame_byte[mmpr_pkg::OFS_VOLTAGE + 1]};
  assign dec_current = {frame_byte[mmpr_pkg::OFS_CURRENT],     frame_byte[mmpr_pkg::OFS_CURRENT + 1],
                        frame_byte[mmpr_pkg::OFS_CURRENT + 2], frame_byte[mmpr_pkg::OFS_CURRENT + 3]};
  assign dec_power   = {frame_byte[mmpr_pkg::OFS_POWER],     frame_byte[mmpr_pkg::OFS_POWER + 1],
                        frame_byte[mmpr_pkg::OFS_POWER + 2], frame_byte[mmpr_pkg::OFS_POWER + 3]};
  assign dec_energy  = {frame_byte[mmpr_pkg::OFS_ENERGY],     frame_byte[mmpr_pkg::OFS_ENERGY + 1],
                        frame_byte[mmpr_pkg::OFS_ENERGY + 2], frame_byte[mmpr_pkg::OFS_ENERGY + 3]};
  assign dec_freq    = {frame_byte[mmpr_pkg::OFS_FREQ], frame_byte[mmpr_pkg::OFS_FREQ + 1]};
  assign dec_pf      = {frame_byte[mmpr_pkg::OFS_PF],   frame_byte[mmpr_pkg::OFS_PF + 1]};
  assign dec_alarm   = {frame_byte[mmpr_pkg::OFS_ALARM], frame_byte[mmpr_pkg::OFS_ALARM + 1]};

  assign range_ok = (dec_voltage >= mmpr_pkg::VOLT_MIN) && (dec_voltage <= mmpr_pkg::VOLT_MAX) &&
                    (dec_current <= mmpr_pkg::CURR_MAX) && (dec_power <= mmpr_pkg::POWER_MAX) &&
                    (dec_freq >= mmpr_pkg::FREQ_MIN) && (dec_freq <= mmpr_pkg::FREQ_MAX) &&
                    (dec_pf <= mmpr_pkg::PF_MAX);

  // ---------------------------------------------------------------------------
  // Tick path: saturating counters, timeout while awaiting, request when idle.
  // ---------------------------------------------------------------------------
  assign poll_sat = (poll_ticks == mmpr_pkg::TICK_SAT) ? poll_ticks : poll_ticks + 16'd1;
  assign wait_sat = (wait_ticks == mmpr_pkg::TICK_SAT) ? wait_ticks : wait_ticks + 16'd1;

  assign timeout_hit = is_tick & awaiting_reply & (wait_sat >= response_timeout);
  assign start_req   = is_tick & ~awaiting_reply & (poll_sat >= poll_interval);

  // ---------------------------------------------------------------------------
  // Report assembly: errors count before they are reported; energy and alarm
  // latch from any frame that passes the header and CRC checks.
  // ---------------------------------------------------------------------------
  assign report_now       = frame_done | timeout_hit;
  assign err_inc          = (frame_done & ~header_ok) | timeout_hit;
  assign error_next       = error_counter + {31'd0, err_inc};
  assign held_energy_next = (frame_done & header_ok) ? dec_energy : held_energy;
  assign held_alarm_next  = (frame_done & header_ok) ? dec_alarm  : held_alarm;
  assign pass_values      = frame_done & header_ok & range_ok;

  always_comb begin
    priority if (timeout_hit) begin
      status_next = mmpr_pkg::STATUS_TIMEOUT;
    end else if (!header_ok) begin
      status_next = mmpr_pkg::STATUS_FRAME;
    end else if (!range_ok) begin
      status_next = mmpr_pkg::STATUS_RANGE;
    end else begin
      status_next = mmpr_pkg::STATUS_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Request bytes: the CRC is a base value plus one column per address bit.
  // ---------------------------------------------------------------------------
  always_comb begin
    req_crc = mmpr_pkg::REQ_CRC_BASE;
    for (int k = 0; k < 8; k++) begin
      if (device_address[k]) begin
        req_crc = req_crc ^ mmpr_pkg::REQ_CRC_COL[k];
      end
    end
  end

  always_comb begin
    req_bytes[0] = device_address;
    req_bytes[1] = mmpr_pkg::FUNC_READ_HOLDING;
    req_bytes[2] = mmpr_pkg::START_REG_HI;
    req_bytes[3] = mmpr_pkg::START_REG_LO;
    req_bytes[4] = mmpr_pkg::REG_COUNT_HI;
    req_bytes[5] = mmpr_pkg::REG_COUNT_LO;
    req_bytes[6] = req_crc[7:0];
    req_bytes[7] = req_crc[15:8];
  end

  assign beat_inc = beat + BW'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= mmpr_pkg::DEVICE_ADDRESS_RESET;
      poll_interval    <= mmpr_pkg::POLL_INTERVAL_RESET;
      response_timeout <= mmpr_pkg::RESPONSE_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmpr_pkg::REG_DEVICE_ADDRESS:   device_address   <= cfg_data[7:0];
        mmpr_pkg::REG_POLL_INTERVAL:    poll_interval    <= cfg_data;
        mmpr_pkg::REG_RESPONSE_TIMEOUT: response_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Poll and reply state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_reply <= 1'b0;
      poll_ticks     <= '0;
      wait_ticks     <= '0;
      byte_count     <= '0;
      running_crc    <= mmpr_pkg::CRC_INIT;
      error_counter  <= '0;
      held_energy    <= '0;
      held_alarm     <= '0;
    end else begin
      error_counter <= error_next;
      held_energy   <= held_energy_next;
      held_alarm    <= held_alarm_next;

      if (is_tick) begin
        poll_ticks <= start_req ? '0 : poll_sat;
        if (awaiting_reply) begin
          wait_ticks <= wait_sat;
        end
      end

      if (timeout_hit) begin
        awaiting_reply <= 1'b0;
        byte_count     <= '0;
      end

      if (start_req) begin
        awaiting_reply <= 1'b1;
        wait_ticks     <= '0;
        byte_count     <= '0;
        running_crc    <= mmpr_pkg::CRC_INIT;
      end

      if (take_byte) begin
        // The two CRC bytes of the reply stay out of the running CRC.
        if (byte_count < CW'(RB - 2)) begin
          running_crc <= crc_next;
        end
        byte_count <= frame_done ? '0 : count_inc;
        if (frame_done) begin
          awaiting_reply <= 1'b0;
        end
      end
    end
  end

  // Reply shift line: advance on every captured byte.
  always_ff @(posedge clk) begin
    if (take_byte) begin
      frame_shift[0] <= rx_byte;
      for (int i = 1; i < mmpr_pkg::SHIFT_DEPTH; i++) begin
        frame_shift[i] <= frame_shift[i - 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register control: an item that causes a result loads it, otherwise a transfer
  // advances the request burst or empties it on the last result.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else begin
      priority if (start_req) begin
        out_valid <= 1'b1;
        beat      <= '0;
      end else if (report_now) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        if (last) begin
          out_valid <= 1'b0;
        end else begin
          beat <= beat_inc;
        end
      end else begin
        // hold the register
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    priority if (start_req) begin
      kind             <= mmpr_pkg::KIND_TX;
      tx_byte          <= req_bytes[0];
      last             <= 1'b0;
      status           <= mmpr_pkg::STATUS_OK;
      voltage_dv       <= '0;
      current_ma       <= '0;
      power_dw         <= '0;
      energy_wh        <= '0;
      frequency_dhz    <= '0;
      power_factor_pct <= '0;
      alarm_word       <= '0;
      error_total      <= '0;
    end else if (report_now) begin
      kind             <= mmpr_pkg::KIND_REPORT;
      tx_byte          <= '0;
      last             <= 1'b1;
      status           <= status_next;
      voltage_dv       <= pass_values ? dec_voltage : '0;
      current_ma       <= pass_values ? dec_current : '0;
      power_dw         <= pass_values ? dec_power   : '0;
      energy_wh        <= held_energy_next;
      frequency_dhz    <= pass_values ? dec_freq    : '0;
      power_factor_pct <= pass_values ? dec_pf      : '0;
      alarm_word       <= held_alarm_next;
      error_total      <= error_next;
    end else if (out_fire && !last) begin
      tx_byte <= req_bytes[beat_inc];
      last    <= (beat_inc == BW'(mmpr_pkg::REQ_BYTES - 1));
    end else begin
      // hold the payload
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `MMPR_ASSERT_IMPLIES(a_accept_only_when_drained, in_fire, !out_valid || (out_fire && last), "input transfer while a result is still pending")
  `MMPR_ASSERT_NEXT(a_burst_continues, out_fire && (kind == mmpr_pkg::KIND_TX) && !last, out_valid && (kind == mmpr_pkg::KIND_TX), "request burst broke off before its last byte")
  `MMPR_ASSERT_IMPLIES(a_idle_count_clear, !awaiting_reply, byte_count == '0, "reply byte count nonzero while idle")
  `MMPR_ASSERT_IMPLIES(a_error_fields_zero, out_valid && (kind == mmpr_pkg::KIND_REPORT) && (status != mmpr_pkg::STATUS_OK), (voltage_dv == '0) && (current_ma == '0) && (power_dw == '0), "measurement fields not cleared on a failed report")
  `MMPR_ASSERT_NEXT(a_request_start, start_req, awaiting_reply && out_valid && (kind == mmpr_pkg::KIND_TX) && (tx_byte == $past(device_address)), "request did not start with the device address")

endmodule
